/* design/asfhr_pkg.sv */
`timescale 1ns / 1ps

package asfhr_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_EXTENSION_KIND = 1'd0,
    REG_BUFFER_ONLY    = 1'd1
  } cfg_reg_t;

  // Extension classes
  typedef enum logic [1:0] {
    EXT_UNKNOWN = 2'd0,
    EXT_WMA     = 2'd1,
    EXT_WMV     = 2'd2,
    EXT_ASF     = 2'd3
  } ext_kind_t;

  // MIME codes
  typedef enum logic [2:0] {
    MIME_NONE      = 3'd0,
    MIME_WMA       = 3'd1,
    MIME_WMV       = 3'd2,
    MIME_ASF_VIDEO = 3'd3,
    MIME_ASF_AUDIO = 3'd4
  } mime_t;

  typedef enum logic [3:0] {
    PH_HDR_GUID   = 4'd0,
    PH_HDR_SIZE   = 4'd1,
    PH_COUNT      = 4'd2,
    PH_RESERVED   = 4'd3,
    PH_CHILD_GUID = 4'd4,
    PH_CHILD_SIZE = 4'd5,
    PH_MEDIA_GUID = 4'd6,
    PH_SKIP       = 4'd7,
    PH_DONE       = 4'd8
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] confidence;
    logic [2:0] mime_code;
    logic       has_video;
  } out_item_t;

  // Parser result request toward the output buffer
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_req_t;

  localparam logic [63:0] MIN_HEADER_SIZE = 64'd30;
  localparam logic [63:0] OBJ_HEAD_LEN    = 64'd24;
  localparam logic [63:0] STREAM_HEAD_LEN = 64'd40;

  // Arrival order of GUID bytes in compared form
  localparam logic [3:0] GUID_PLACE [16] = '{
    4'd3, 4'd2, 4'd1, 4'd0, 4'd5, 4'd4, 4'd7, 4'd6,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  localparam logic [7:0] HEADER_GUID [16] = '{
    8'h75, 8'hB2, 8'h26, 8'h30, 8'h66, 8'h8E, 8'h11, 8'hCF,
    8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C
  };

  localparam logic [7:0] STREAM_GUID [16] = '{
    8'hB7, 8'hDC, 8'h07, 8'h91, 8'hA9, 8'hB7, 8'h11, 8'hCF,
    8'h8E, 8'hE6, 8'h00, 8'hC0, 8'h0C, 8'h20, 8'h53, 8'h65
  };

  localparam logic [7:0] VIDEO_GUID [16] = '{
    8'hBC, 8'h19, 8'hEF, 8'hC0, 8'h5B, 8'h4D, 8'h11, 8'hCF,
    8'hA8, 8'hFD, 8'h00, 8'h80, 8'h5F, 8'h5C, 8'h44, 8'h2B
  };

  // Index is {stream seen, header seen, extension known}
  localparam logic [1:0] CONF_TABLE [8] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd3
  };

  // Signed size below a small positive limit
  function automatic logic size_below(input logic [63:0] size, input logic [63:0] limit);
    size_below = size[63] || (size < limit);
  endfunction

endpackage

/* design/asfhr_parser.sv */
`timescale 1ns / 1ps

module asfhr_parser import asfhr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  in_item_t    item,
  input  logic [1:0]  extension_kind,
  input  logic        buffer_only_source,
  output result_req_t result
);

  parse_phase_t phase, phase_next;
  logic [3:0]   count, count_next;
  logic [63:0]  size, size_next;
  logic [31:0]  objects_left, objects_left_next;
  logic [63:0]  skip_left, skip_left_next;
  logic [1:0]   found, found_next;
  logic         video, video_next;
  logic [2:0]   match, match_next;   // {video, stream, header} running GUID compare

  logic [7:0]   b;
  logic [63:0]  size_asm;
  logic [31:0]  count_asm;
  logic [63:0]  size_now;
  logic [63:0]  head_len;
  logic         start_skip;
  logic         next_obj;
  logic [2:0]   match_base;
  logic [3:0]   place;
  logic [1:0]   found_end;
  logic         video_end;
  logic [1:0]   conf;
  mime_t        mime;

  assign b     = item.data_byte;
  assign place = GUID_PLACE[count];

  // Assemble little-endian fields one lane at a time
  always_comb begin
    size_asm  = (count == 4'd0) ? 64'd0 : size;
    count_asm = (count == 4'd0) ? 32'd0 : objects_left;
    for (int i = 0; i < 8; i++) begin
      if (count[2:0] == 3'(i)) size_asm[8*i +: 8] = b;
    end
    for (int i = 0; i < 4; i++) begin
      if (count[1:0] == 2'(i)) count_asm[8*i +: 8] = b;
    end
  end

  assign match_base = (count == 4'd0) ? 3'b111 : match;

  // Advance the parse by one byte
  always_comb begin
    phase_next        = phase;
    count_next        = count;
    size_next         = size;
    objects_left_next = objects_left;
    skip_left_next    = skip_left;
    found_next        = found;
    video_next        = video;
    match_next        = match;
    start_skip        = 1'b0;
    next_obj          = 1'b0;
    head_len          = OBJ_HEAD_LEN;
    size_now          = size;

    if (take) begin
      if (phase == PH_HDR_GUID && count == 4'd0) video_next = buffer_only_source;

      case (phase)
        PH_HDR_GUID, PH_CHILD_GUID, PH_MEDIA_GUID: begin
          match_next[0] = match_base[0] && (b == HEADER_GUID[place]);
          match_next[1] = match_base[1] && (b == STREAM_GUID[place]);
          match_next[2] = match_base[2] && (b == VIDEO_GUID[place]);
          count_next    = count + 4'd1;
          if (count == 4'd15) begin
            count_next = 4'd0;
            if (phase == PH_HDR_GUID) begin
              phase_next = PH_HDR_SIZE;
            end else if (phase == PH_CHILD_GUID) begin
              phase_next = PH_CHILD_SIZE;
            end else begin
              if (match_next[2]) video_next = 1'b1;
              start_skip = 1'b1;
              head_len   = STREAM_HEAD_LEN;
            end
          end
        end
        PH_HDR_SIZE, PH_CHILD_SIZE: begin
          size_next  = size_asm;
          size_now   = size_asm;
          count_next = count + 4'd1;
          if (count == 4'd7) begin
            count_next = 4'd0;
            if (phase == PH_HDR_SIZE) begin
              if (!match[0] || size_below(size_asm, MIN_HEADER_SIZE)) begin
                video_next = 1'b1;
                phase_next = PH_DONE;
              end else begin
                found_next[0] = 1'b1;
                phase_next    = PH_COUNT;
              end
            end else if (match[1]) begin
              found_next[1] = 1'b1;
              phase_next    = PH_MEDIA_GUID;
            end else begin
              start_skip = 1'b1;
            end
          end
        end
        PH_COUNT: begin
          objects_left_next = count_asm;
          count_next        = count + 4'd1;
          if (count == 4'd3) begin
            count_next = 4'd0;
            phase_next = PH_RESERVED;
          end
        end
        PH_RESERVED: begin
          count_next = count + 4'd1;
          if (count == 4'd1) next_obj = 1'b1;
        end
        PH_SKIP: begin
          skip_left_next = skip_left - 64'd1;
          if (skip_left == 64'd1) next_obj = 1'b1;
        end
        default: begin
        end
      endcase

      // Skip the rest of an object, move on when nothing is left, or stop on a negative skip
      if (start_skip) begin
        if (size_below(size_now, head_len)) begin
          phase_next = PH_DONE;
        end else if (size_now == head_len) begin
          next_obj = 1'b1;
        end else begin
          phase_next     = PH_SKIP;
          skip_left_next = size_now - head_len;
        end
      end

      // Move to the next child or finish
      if (next_obj) begin
        count_next = 4'd0;
        if (objects_left == 32'd0) begin
          phase_next = PH_DONE;
        end else begin
          objects_left_next = objects_left - 32'd1;
          phase_next        = PH_CHILD_GUID;
        end
      end
    end

    // Keep the flags of the file that ends with this byte
    found_end = found_next;
    video_end = video_next;

    // Start over for a new file after the final byte
    if (take && item.last_byte) begin
      phase_next = PH_HDR_GUID;
      count_next = 4'd0;
      found_next = 2'b00;
      video_next = buffer_only_source;
    end
  end

  // Build the result from the flags after this byte
  always_comb begin
    conf = CONF_TABLE[{found_end, (extension_kind != EXT_UNKNOWN)}];
    mime = MIME_NONE;
    if (conf != 2'd0) begin
      case (ext_kind_t'(extension_kind))
        EXT_WMA: mime = MIME_WMA;
        EXT_WMV: mime = MIME_WMV;
        default: mime = video_end ? MIME_ASF_VIDEO : MIME_ASF_AUDIO;
      endcase
    end
  end

  always_comb begin
    result.valid           = take && item.last_byte;
    result.item.confidence = conf;
    result.item.mime_code  = mime;
    result.item.has_video  = video_end;
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR_GUID;
      count        <= 4'd0;
      found        <= 2'b00;
      video        <= 1'b0;
      objects_left <= 32'd0;
      skip_left    <= 64'd0;
      size         <= 64'd0;
    end else begin
      phase        <= phase_next;
      count        <= count_next;
      found        <= found_next;
      video        <= video_next;
      objects_left <= objects_left_next;
      skip_left    <= skip_left_next;
      size         <= size_next;
    end
  end

  always_ff @(posedge clk) begin
    match <= match_next;
  end

endmodule

/* design/asfhr_out_buf.sv */
`timescale 1ns / 1ps

module asfhr_out_buf import asfhr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  result_req_t push,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  logic [1:0] fill;
  logic [1:0] fill_next;
  out_item_t  head;
  out_item_t  tail;
  logic       pop;

  assign pop       = (fill != 2'd0) && !out_stall;
  assign full      = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_item  = head;

  always_comb begin
    fill_next = fill;
    if (push.valid && !pop) fill_next = fill + 2'd1;
    else if (!push.valid && pop) fill_next = fill - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill_next;
    end
  end

  // Shift the tail forward on pop; land a new request in the first free slot
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push.valid && fill == 2'd1) head <= push.item;
      else head <= tail;
    end else if (push.valid) begin
      if (fill == 2'd0) head <= push.item;
      else tail <= push.item;
    end
  end

endmodule

/* design/asf_header_recogniser.sv */
`timescale 1ns / 1ps

// ASF header recogniser. Takes one file byte per cycle on the input channel
// (unless in_stall holds it) and walks the ASF header object: header GUID
// and size, child count, then each child object (stream properties are
// inspected, others skipped by size). Each byte is consumed in the cycle it
// is accepted, so the sustained rate is one byte per clock while in_stall
// is low; the byte flagged last_byte produces one result (confidence, MIME
// code, video flag), after which parsing restarts for a new file. Results
// go through a two-entry output buffer; in_stall rises only while both
// entries hold results the consumer has not taken. Configuration writes are
// always ready and should be issued only while no file is in progress.

module asf_header_recogniser import asfhr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [1:0]  extension_kind;
  logic        buffer_only_source;
  logic        take;
  logic        full;
  result_req_t result;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign take      = in_valid && !full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      extension_kind     <= 2'd0;
      buffer_only_source <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_EXTENSION_KIND: extension_kind     <= cfg_data[1:0];
        REG_BUFFER_ONLY:    buffer_only_source <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  asfhr_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .item               (in_item),
    .extension_kind     (extension_kind),
    .buffer_only_source (buffer_only_source),
    .result             (result)
  );

  asfhr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import asfhr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 4;

  // GUIDs in compared byte order, byte 0 in the top bits
  localparam logic [127:0] HDR_GUID_C    = 128'h75B22630668E11CFA6D900AA0062CE6C;
  localparam logic [127:0] STREAM_GUID_C = 128'hB7DC0791A9B711CF8EE600C00C205365;
  localparam logic [127:0] VIDEO_GUID_C  = 128'hBC19EFC05B4D11CFA8FD00805F5C442B;
  localparam logic [63:0]  HDR_MIN_SIZE  = 64'd30;
  localparam logic [63:0]  CHILD_HEAD    = 64'd24;
  localparam logic [63:0]  STREAM_HEAD   = 64'd40;
  localparam logic [1:0]   NOT_RECOGNISED = 2'd0;
  localparam logic [1:0]   CONF_BY_INDEX [8] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd3
  };

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  asf_header_recogniser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Parser shadow state and register copies
  ext_kind_t    ext_sel;
  logic         buffer_only;
  parse_phase_t ph;
  int           nb;
  logic [127:0] guid_acc;
  logic [63:0]  size_acc;
  logic [63:0]  skip_left;
  logic [31:0]  objects_left;
  logic [1:0]   found;
  logic         video_seen;
  logic         corrupt_seen;

  out_item_t    pending_verdicts [$];
  logic [7:0]   file_bytes [$];
  int           mismatch_count;
  int           idle_cycles;
  int           sender_idle_pct;
  int           receiver_idle_pct;
  int           hold_left;
  bit           hold_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Position in compared form of the n-th GUID byte on the wire
  function automatic int arrival_slot(input int n);
    if (n < 4) return 3 - n;
    else if (n < 8) return n ^ 1;
    else return n;
  endfunction

  function automatic logic [127:0] random_guid();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] flip_bit(input logic [127:0] g);
    int pos;
    pos = $urandom_range(127);
    g[pos] = ~g[pos];
    return g;
  endfunction

  function automatic logic size_short(input logic [63:0] sz, input logic [63:0] head);
    return $signed(sz) < $signed(head);
  endfunction

  task automatic clear_file_state();
    ph           = PH_HDR_GUID;
    nb           = 0;
    guid_acc     = '0;
    size_acc     = '0;
    skip_left    = '0;
    objects_left = '0;
    found        = '0;
    video_seen   = buffer_only;
    corrupt_seen = 1'b0;
  endtask

  task automatic enter_next_object();
    nb = 0;
    if (objects_left == 0) begin
      ph = PH_DONE;
    end else begin
      objects_left--;
      ph = PH_CHILD_GUID;
    end
  endtask

  task automatic begin_skip(input logic [63:0] head);
    if (size_short(size_acc, head)) begin
      ph = PH_DONE;
    end else begin
      skip_left = size_acc - head;
      if (skip_left == 0) enter_next_object();
      else ph = PH_SKIP;
    end
  endtask

  // Advance the shadow parser by one accepted byte; queue the verdict on the last
  task automatic parse_file_byte(input in_item_t req);
    out_item_t  verdict;
    logic [2:0] idx;
    if (ph == PH_HDR_GUID && nb == 0) video_seen = buffer_only;
    case (ph)
      PH_HDR_GUID, PH_CHILD_GUID, PH_MEDIA_GUID: begin
        guid_acc[127 - 8 * arrival_slot(nb) -: 8] = req.data_byte;
        nb++;
        if (nb == 16) begin
          nb = 0;
          if (ph == PH_HDR_GUID) begin
            ph = PH_HDR_SIZE;
          end else if (ph == PH_CHILD_GUID) begin
            ph = PH_CHILD_SIZE;
          end else begin
            if (guid_acc == VIDEO_GUID_C) video_seen = 1'b1;
            begin_skip(STREAM_HEAD);
          end
        end
      end
      PH_HDR_SIZE, PH_CHILD_SIZE: begin
        if (nb == 0) size_acc = '0;
        size_acc[8 * nb +: 8] = req.data_byte;
        nb++;
        if (nb == 8) begin
          nb = 0;
          if (ph == PH_HDR_SIZE) begin
            if (guid_acc != HDR_GUID_C || size_short(size_acc, HDR_MIN_SIZE)) begin
              corrupt_seen = 1'b1;
              video_seen   = 1'b1;
              ph           = PH_DONE;
            end else begin
              found[0] = 1'b1;
              ph       = PH_COUNT;
            end
          end else if (guid_acc == STREAM_GUID_C) begin
            found[1] = 1'b1;
            ph       = PH_MEDIA_GUID;
          end else begin
            begin_skip(CHILD_HEAD);
          end
        end
      end
      PH_COUNT: begin
        if (nb == 0) objects_left = '0;
        objects_left[8 * nb +: 8] = req.data_byte;
        nb++;
        if (nb == 4) begin
          nb = 0;
          ph = PH_RESERVED;
        end
      end
      PH_RESERVED: begin
        nb++;
        if (nb == 2) enter_next_object();
      end
      PH_SKIP: begin
        skip_left--;
        if (skip_left == 0) enter_next_object();
      end
      default: begin
      end
    endcase

    if (req.last_byte) begin
      idx = {found[1], found[0], ext_sel != EXT_UNKNOWN};
      verdict.confidence = CONF_BY_INDEX[idx];
      verdict.has_video  = video_seen;
      if (verdict.confidence == NOT_RECOGNISED) begin
        verdict.mime_code = MIME_NONE;
      end else begin
        case (ext_sel)
          EXT_WMA: verdict.mime_code = MIME_WMA;
          EXT_WMV: verdict.mime_code = MIME_WMV;
          default: verdict.mime_code = video_seen ? MIME_ASF_VIDEO : MIME_ASF_AUDIO;
        endcase
      end
      pending_verdicts.push_back(verdict);
      clear_file_state();
    end
  endtask

  // Offer one request; hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t req;
    req = '{data_byte: b, last_byte: last};
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    parse_file_byte(req);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  // Drop valid, then wait for every verdict and a short settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_EXTENSION_KIND: ext_sel = ext_kind_t'(val);
      REG_BUFFER_ONLY:    buffer_only = val[0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
  endtask

  // File building blocks
  task automatic push_guid(input logic [127:0] g);
    for (int n = 0; n < 16; n++) file_bytes.push_back(g[127 - 8 * arrival_slot(n) -: 8]);
  endtask

  task automatic push_le(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic push_header(input logic [63:0] sz, input logic [31:0] count);
    push_guid(HDR_GUID_C);
    push_le(sz, 8);
    push_le(64'(count), 4);
    push_random(2);
  endtask

  // Child with its body, when the size makes sense and is short
  task automatic push_child(input logic [127:0] g, input logic [63:0] sz,
                            input logic [127:0] media);
    logic [63:0] head;
    head = (g == STREAM_GUID_C) ? STREAM_HEAD : CHILD_HEAD;
    push_guid(g);
    push_le(sz, 8);
    if (g == STREAM_GUID_C) push_guid(media);
    if (!size_short(sz, head) && sz - head <= 64) push_random(int'(sz - head));
  endtask

  task automatic start_file();
    file_bytes.delete();
  endtask

  function automatic logic [63:0] random_child_size(input logic [63:0] head);
    int roll;
    roll = $urandom_range(99);
    if (roll < 82) return head + 64'($urandom_range(0, 16));
    else if (roll < 92) return 64'($urandom_range(0, int'(head) - 1));
    else if (roll < 96) return {1'b1, 31'($urandom), $urandom};
    else return {2'b01, 30'($urandom), $urandom};
  endfunction

  task automatic make_random_file();
    int          roll;
    int          n_child;
    int          cut;
    logic [127:0] g;
    logic [63:0]  sz;
    logic [31:0]  count;
    start_file();
    roll = $urandom_range(99);
    if (roll < 15) begin
      push_random($urandom_range(1, 40));
      return;
    end
    g = HDR_GUID_C;
    if ($urandom_range(99) < 8) g = flip_bit(g);
    push_guid(g);
    roll = $urandom_range(99);
    if (roll < 85) sz = 64'($urandom_range(30, 3000));
    else if (roll < 93) sz = 64'($urandom_range(0, 29));
    else sz = {1'b1, 31'($urandom), $urandom};
    push_le(sz, 8);
    n_child = $urandom_range(0, 4);
    roll = $urandom_range(99);
    if (roll < 80) count = 32'(n_child);
    else if (roll < 92) count = 32'(n_child + $urandom_range(1, 3));
    else count = $urandom;
    push_le(64'(count), 4);
    push_random(2);
    for (int k = 0; k < n_child; k++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        g = ($urandom_range(1) != 0) ? VIDEO_GUID_C : random_guid();
        if ($urandom_range(99) < 10) g = flip_bit(g);
        push_child(STREAM_GUID_C, random_child_size(STREAM_HEAD), g);
      end else begin
        g = (roll < 55) ? flip_bit(STREAM_GUID_C) : random_guid();
        push_child(g, random_child_size(CHILD_HEAD), '0);
      end
    end
    push_random($urandom_range(0, 6));
    // Cut some files short inside whatever field they reach
    if ($urandom_range(99) < 20) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) file_bytes.delete(file_bytes.size() - 1);
    end
  endtask

  // Tests
  task automatic test_register_settings();
    for (int e = 0; e < 4; e++) begin
      for (int bo = 0; bo < 2; bo++) begin
        write_register(REG_EXTENSION_KIND, CFG_DATA_W'(e));
        write_register(REG_BUFFER_ONLY, CFG_DATA_W'(bo));
        start_file();
        file_bytes.push_back(bo != 0 ? 8'hFF : 8'h00);
        send_file();
        start_file();
        push_header(64'd70, 32'd1);
        send_file();
      end
    end
  endtask

  task automatic test_corrupt_headers();
    write_register(REG_EXTENSION_KIND, EXT_ASF);
    write_register(REG_BUFFER_ONLY, 2'd0);
    start_file();
    push_guid(HDR_GUID_C ^ 128'd1);
    push_le(HDR_MIN_SIZE, 8);
    push_random(6);
    send_file();
    start_file();
    push_header(64'd29, 32'd0);
    send_file();
    start_file();
    push_header(64'h8000_0000_0000_0000, 32'd0);
    send_file();
    start_file();
    push_header(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_file();
    // Smallest legal header, no children, trailing bytes ignored
    start_file();
    push_header(HDR_MIN_SIZE, 32'd0);
    push_le(64'hFFFF_FFFF, 4);
    send_file();
  endtask

  task automatic test_child_objects();
    start_file();
    push_header(64'h7FFF_FFFF_FFFF_FFFF, 32'd3);
    push_child(STREAM_GUID_C, STREAM_HEAD, VIDEO_GUID_C);
    push_child(random_guid(), CHILD_HEAD, '0);
    push_child(random_guid(), 64'd30, '0);
    push_le(64'hAAAAAA, 3);
    send_file();
    start_file();
    push_header(64'd100, 32'd1);
    push_child(STREAM_GUID_C, 64'd41, random_guid());
    send_file();
    // Count promises more children than follow
    start_file();
    push_header(64'd100, 32'hFFFF_FFFF);
    push_child(random_guid(), 64'd25, '0);
    push_random(9);
    send_file();
  endtask

  task automatic test_negative_skip();
    write_register(REG_EXTENSION_KIND, EXT_UNKNOWN);
    start_file();
    push_header(64'd200, 32'd2);
    push_child(random_guid(), 64'd23, '0);
    push_child(STREAM_GUID_C, STREAM_HEAD, VIDEO_GUID_C);
    send_file();
    start_file();
    push_header(64'd200, 32'd1);
    push_child(STREAM_GUID_C, 64'd39, VIDEO_GUID_C);
    push_random(4);
    send_file();
    start_file();
    push_header(64'd200, 32'd1);
    push_child(random_guid(), 64'hFFFF_FFFF_FFFF_FFFF, '0);
    push_random(4);
    send_file();
  endtask

  // End a file inside each field in turn
  task automatic test_early_end();
    int cut_points [8] = '{5, 20, 26, 29, 40, 50, 60, 75};
    write_register(REG_EXTENSION_KIND, EXT_ASF);
    foreach (cut_points[i]) begin
      start_file();
      push_header(64'd500, 32'd2);
      push_child(STREAM_GUID_C, 64'd50, VIDEO_GUID_C);
      push_child(random_guid(), 64'd30, '0);
      while (file_bytes.size() > cut_points[i]) file_bytes.delete(file_bytes.size() - 1);
      send_file();
    end
  endtask

  task automatic test_random_files(input int byte_goal, input int file_goal);
    int bytes_sent;
    int files_sent;
    bytes_sent = 0;
    files_sent = 0;
    write_register(REG_EXTENSION_KIND, CFG_DATA_W'($urandom_range(3)));
    write_register(REG_BUFFER_ONLY, CFG_DATA_W'($urandom_range(1)));
    while (bytes_sent < byte_goal || files_sent < file_goal) begin
      make_random_file();
      bytes_sent += file_bytes.size();
      files_sent++;
      send_file();
    end
  endtask

  // Stall the output for a long stretch while single-byte files keep coming
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    for (int k = 0; k < 40; k++) begin
      start_file();
      push_random(1);
      send_file();
    end
  endtask

  // Receiver: random stalls, or a long hold on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each taken result with the oldest verdict
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual conf %0d mime %0d video %0d",
                 $time, out_item.confidence, out_item.mime_code, out_item.has_video);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("confidence", want.confidence, out_item.confidence);
        check_field("mime_code", want.mime_code, out_item.mime_code);
        check_field("has_video", want.has_video, out_item.has_video);
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_EXTENSION_KIND;
    cfg_data       = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    hold_left      = 0;
    hold_request   = 1'b0;
    ext_sel        = EXT_UNKNOWN;
    buffer_only    = 1'b0;
    clear_file_state();
    set_idling(11, 65);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_settings();
    test_corrupt_headers();
    test_child_objects();
    test_negative_skip();
    test_early_end();
    test_random_files(30, 1);
    set_idling(65, 11);
    test_random_files(30, 1);
    set_idling(0, 0);
    test_output_backpressure();
    test_random_files(30, 1);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
design/asfhr_pkg.sv
design/asfhr_parser.sv
design/asfhr_out_buf.sv
design/asf_header_recogniser.sv
tb/sv/tb.sv
